>>> hdl/b64e_pkg.sv
// Package with the shared types, constants and alphabet lookup of the base64 stream encoder.
`timescale 1ns / 1ps

package b64e_pkg;

    localparam int LINE_CHARS = 64;
    localparam int COL_W = $clog2(LINE_CHARS);
    localparam logic [COL_W:0] LINE_END = (COL_W + 1)'(LINE_CHARS);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] NL_CHAR = 8'd10;
    localparam logic [7:0] PAD_CHAR = 8'd61;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE = 2'd1;
    localparam logic [1:0] HELD_TWO = 2'd2;

    localparam logic [2:0] SLOT_C0 = 3'd0;
    localparam logic [2:0] SLOT_C1 = 3'd1;
    localparam logic [2:0] SLOT_C2 = 3'd2;
    localparam logic [2:0] SLOT_C3 = 3'd3;
    localparam logic [2:0] SLOT_DONE = 3'd4;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       last;
    } group_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        priority if (v < 6'd26)
            c = 8'd65 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'd71 + {2'b00, v};
        else if (v < 6'd62)
            c = {2'b00, v} - 8'd4;
        else if (v == 6'd62)
            c = 8'd43;
        else
            c = 8'd47;
        return c;
    endfunction

endpackage

>>> hdl/b64e_front.sv
// Front end: accepts bytes, holds a partial group and pushes complete or final groups.
`timescale 1ns / 1ps

module b64e_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,  // data_byte
    input  logic             s_axis_tlast,
    output b64e_pkg::group_t grp,
    output logic             grp_push,
    input  logic             q_full
);
    import b64e_pkg::*;

    logic [7:0] held0_reg;
    logic [7:0] held1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       accept;
    logic       complete;

    assign s_axis_tready = !q_full;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign complete = (cnt_reg == HELD_TWO) || s_axis_tlast;
    assign grp_push = accept && complete;

    always_comb
    begin
        grp.last = s_axis_tlast;
        grp.nbytes = cnt_reg + 2'd1;
        unique case (cnt_reg)
            HELD_NONE:
            begin
                grp.b0 = s_axis_tdata;
                grp.b1 = 8'd0;
                grp.b2 = 8'd0;
            end
            HELD_ONE:
            begin
                grp.b0 = held0_reg;
                grp.b1 = s_axis_tdata;
                grp.b2 = 8'd0;
            end
            HELD_TWO:
            begin
                grp.b0 = held0_reg;
                grp.b1 = held1_reg;
                grp.b2 = s_axis_tdata;
            end
            default:
            begin
                grp.b0 = 8'd0;
                grp.b1 = 8'd0;
                grp.b2 = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (complete)
                cnt_next = HELD_NONE;
            else
                cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= HELD_NONE;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !complete)
        begin
            if (cnt_reg == HELD_NONE)
                held0_reg <= s_axis_tdata;
            else
                held1_reg <= s_axis_tdata;
        end
    end

endmodule

>>> hdl/b64e_fifo.sv
// Short queue of byte groups between the front end and the character sequencer.
`timescale 1ns / 1ps

module b64e_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  b64e_pkg::group_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output b64e_pkg::group_t rd_data,
    output logic             not_empty
);
    import b64e_pkg::*;

    group_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg;
    logic [FIFO_CNT_W-1:0]   cnt_next;
    logic                    do_wr;
    logic                    do_rd;

    assign full = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && not_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            if (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            if (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> hdl/b64e_back.sv
// Back end: turns one group into characters, wrap newlines and the closing newline.
`timescale 1ns / 1ps

module b64e_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  b64e_pkg::group_t q_data,
    input  logic             q_avail,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // out_char
    output logic             m_axis_tlast
);
    import b64e_pkg::*;

    group_t           grp_reg;
    logic             grp_valid_reg;
    logic             grp_valid_next;
    logic [2:0]       slot_reg;
    logic [2:0]       slot_next;
    logic             nl_reg;
    logic             nl_next;
    logic             nl_end_reg;
    logic             nl_end_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_char_reg;
    logic [7:0]       out_char_next;
    logic             out_end_reg;
    logic             out_end_next;

    logic             step;
    logic             finish;
    logic [COL_W:0]   col_inc;
    logic             wrap;
    logic [5:0]       sextet;
    logic             use_pad;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_char_reg;
    assign m_axis_tlast = out_end_reg;

    assign step = grp_valid_reg && (!out_valid_reg || m_axis_tready);
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign wrap = (col_inc == LINE_END);

    always_comb
    begin
        unique case (slot_reg)
            SLOT_C0:
            begin
                sextet = grp_reg.b0[7:2];
                use_pad = 1'b0;
            end
            SLOT_C1:
            begin
                sextet = {grp_reg.b0[1:0], grp_reg.b1[7:4]};
                use_pad = 1'b0;
            end
            SLOT_C2:
            begin
                sextet = {grp_reg.b1[3:0], grp_reg.b2[7:6]};
                use_pad = (grp_reg.nbytes == 2'd1);
            end
            SLOT_C3:
            begin
                sextet = grp_reg.b2[5:0];
                use_pad = (grp_reg.nbytes != 2'd3);
            end
            default:
            begin
                sextet = 6'd0;
                use_pad = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        slot_next = slot_reg;
        nl_next = nl_reg;
        nl_end_next = nl_end_reg;
        col_next = col_reg;
        finish = 1'b0;
        out_char_next = out_char_reg;
        out_end_next = out_end_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (step)
        begin
            out_valid_next = 1'b1;
            if (nl_reg)
            begin
                out_char_next = NL_CHAR;
                out_end_next = nl_end_reg;
                col_next = '0;
                nl_next = 1'b0;
                finish = (slot_reg == SLOT_DONE);
            end
            else
            begin
                out_char_next = use_pad ? PAD_CHAR : b64_char(sextet);
                out_end_next = 1'b0;
                col_next = wrap ? '0 : col_inc[COL_W-1:0];
                slot_next = slot_reg + 3'd1;
                // The final group always closes with one newline, wrap or not.
                if (slot_reg == SLOT_C3)
                begin
                    nl_next = wrap || grp_reg.last;
                    nl_end_next = grp_reg.last;
                    finish = !(wrap || grp_reg.last);
                end
                else
                begin
                    nl_next = wrap;
                    nl_end_next = 1'b0;
                end
            end
        end
        q_pop = q_avail && (!grp_valid_reg || finish);
        grp_valid_next = q_pop ? 1'b1 : (finish ? 1'b0 : grp_valid_reg);
        if (q_pop)
        begin
            slot_next = SLOT_C0;
            nl_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            slot_reg <= SLOT_C0;
            nl_reg <= 1'b0;
            nl_end_reg <= 1'b0;
            col_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            slot_reg <= slot_next;
            nl_reg <= nl_next;
            nl_end_reg <= nl_end_next;
            col_reg <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            grp_reg <= q_data;
        out_char_reg <= out_char_next;
        out_end_reg <= out_end_next;
    end

endmodule

>>> hdl/base64_stream_encoder.sv
// Top level of the line-wrapped base64 stream encoder.
// A group's first character passes through the group queue, the group register and out_char_reg.
// Throughput: one byte per cycle in while the queue is not full, one character per cycle out
// while m_axis_tready is high; each group gives four characters and at most one newline.
// Reset empties the partial group, clears the line column, the group queue and the output valid.
`timescale 1ns / 1ps

module base64_stream_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // out_char
    output logic       m_axis_tlast
);
    import b64e_pkg::*;

    group_t push_grp;
    group_t pop_grp;
    logic   push;
    logic   q_full;
    logic   q_avail;
    logic   pop;

    b64e_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .grp           (push_grp),
        .grp_push      (push),
        .q_full        (q_full)
    );

    b64e_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_data   (push_grp),
        .full      (q_full),
        .rd_en     (pop),
        .rd_data   (pop_grp),
        .not_empty (q_avail)
    );

    b64e_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (pop_grp),
        .q_avail       (q_avail),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> test/tb.sv
// Self-checking testbench for the line-wrapped base64 stream encoder.
`timescale 1ns / 1ps

module tb;

    import b64e_pkg::*;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;  // data_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;  // out_char
    logic       m_axis_tlast;

    enc_char_t   expected_chars[$];
    logic [7:0]  held_bytes[2];
    int          held_count;
    int          line_col;
    bit          no_gaps;
    int unsigned mismatches;
    int unsigned bytes_sent;
    int unsigned messages_sent;
    int unsigned chars_checked;

    base64_stream_encoder u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] chars[8];
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        logic [7:0] c;
        int         cnt;
        int         n;
        n = 0;
        cnt = held_count + 1;
        g0 = (held_count == 0) ? b : held_bytes[0];
        g1 = (held_count == 1) ? b : ((held_count == 2) ? held_bytes[1] : 8'd0);
        g2 = (held_count == 2) ? b : 8'd0;
        if (cnt < 3 && !fin)
        begin
            held_bytes[held_count] = b;
            held_count = cnt;
            return;
        end
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0: c = sextet_char(g0[7:2]);
                1: c = sextet_char({g0[1:0], g1[7:4]});
                2: c = (cnt > 1) ? sextet_char({g1[3:0], g2[7:6]}) : PAD_CHAR;
                default: c = (cnt > 2) ? sextet_char(g2[5:0]) : PAD_CHAR;
            endcase
            chars[n] = c;
            n++;
            line_col++;
            if (line_col >= LINE_CHARS)
            begin
                chars[n] = NL_CHAR;
                n++;
                line_col = 0;
            end
        end
        held_bytes[0] = 8'd0;
        held_bytes[1] = 8'd0;
        held_count = 0;
        if (fin && line_col != 0)
        begin
            chars[n] = NL_CHAR;
            n++;
        end
        if (fin)
            line_col = 0;
        for (int k = 0; k < n; k++)
            expected_chars.push_back('{ch: chars[k], last: fin && (k == n - 1)});
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!no_gaps && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'($urandom);
            s_axis_tlast <= 1'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        encode_byte(b, fin);
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        if (fin)
            messages_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), i == len - 1);
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%t mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin : char_check
        enc_char_t oldest;
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 21);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
                note_mismatch($sformatf("unexpected char %02h last %b",
                                        m_axis_tdata, m_axis_tlast));
            else
            begin
                oldest = expected_chars.pop_front();
                if (m_axis_tdata !== oldest.ch || m_axis_tlast !== oldest.last)
                    note_mismatch($sformatf("expected char %02h last %b, got %02h last %b",
                                            oldest.ch, oldest.last,
                                            m_axis_tdata, m_axis_tlast));
            end
        end
    end

    task automatic test_directed_edges();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    task automatic test_short_messages(input int items, input int max_len);
        int target;
        target = bytes_sent + items;
        while (bytes_sent < target)
            send_message($urandom_range(max_len, 1));
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        test_short_messages(70, 20);
        no_gaps = 1'b0;
    endtask

    task automatic test_line_wrap();
        send_message(48);
        send_message($urandom_range(52, 44));
        send_message($urandom_range(100, 60));
    endtask

    initial
    begin
        no_gaps = 1'b0;
        held_bytes[0] = 8'd0;
        held_bytes[1] = 8'd0;
        held_count = 0;
        line_col = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_short_messages(120, 7);
        test_back_to_back();
        test_line_wrap();
        s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes in %0d messages, checked %0d encoded characters",
                 bytes_sent, messages_sent, chars_checked);
        $display("including padding, line wraps and closing newlines; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d characters still expected.", expected_chars.size());
        $display("tb NOT OK");
        $finish;
    end

endmodule
